@@ design/sorted_key_table_defines.svh @@
// assertion macros for the sorted key table
// no dependencies; included by the top level only
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SKT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_table check failed");
// next-cycle implication
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_table check failed");
`else
`define SKT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/skt_pkg.sv @@
// types and constants shared by the sorted key table modules
// no dependencies
package skt_pkg;

  localparam int CODE_W     = 20;  // code field width
  localparam int POS_W      = 7;   // position / index field width
  localparam int STATUS_W   = 2;
  localparam int CAPACITY_D = 64;
  localparam int CODE_BITS_D = 20;
  localparam int GROUP      = 8;   // cells per first-level reduction group

  typedef enum logic {
    CMD_SEARCH = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_FIN
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] index;
    status_t          status;
  } rsp_t;

  // per-cell compare results handed to the reduction
  typedef struct packed {
    logic eq;    // used entry equals the key
    logic viol;  // insert would break ordering at this cell
  } cell_flag_t;

endpackage

@@ design/skt_cell.sv @@
// one table entry: holds a code, compares it to the broadcast key,
// shifts up from its lower neighbor on insert; uses skt_pkg
module skt_cell
  import skt_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int CODE_B = CODE_BITS_D,
  parameter int CNT_W  = 7,
  parameter int PW     = 7
) (
  input  logic              clk,
  input  logic [CODE_B-1:0] key,
  input  logic [PW-1:0]     pos,
  input  logic [CNT_W-1:0]  count,
  input  logic              shift_en,
  input  logic [CODE_B-1:0] prev_code,
  output logic [CODE_B-1:0] code,
  input  logic              next_lt,
  output logic              lt,
  output logic [CNT_W-1:0]  idx,
  output cell_flag_t        flags
);

  logic used;
  logic lt_raw;
  logic gt_raw;
  logic at_pos;
  logic below_pos;

  assign used      = count > CNT_W'(IDX);
  assign lt_raw    = code < key;
  assign gt_raw    = code > key;
  assign at_pos    = pos == PW'(IDX);
  assign below_pos = pos == PW'(IDX + 1);

  always_ff @(posedge clk) begin
    lt         <= used && lt_raw;
    flags.eq   <= used && !lt_raw && !gt_raw;
    // entry below the position must be smaller, entry at it must be larger
    flags.viol <= (below_pos && !lt_raw) || (at_pos && used && !gt_raw);
    if (shift_en) begin
      if (at_pos) begin
        code <= key;
      end else if (pos < PW'(IDX)) begin
        code <= prev_code;
      end
    end
  end

  // last cell below the key marks the boundary of the sorted run
  assign idx = (lt && !next_lt) ? CNT_W'(IDX + 1) : '0;

endmodule

@@ design/skt_reduce.sv @@
// two-level or-reduction of the per-cell results: registered groups,
// then a final combine; uses skt_pkg
module skt_reduce
  import skt_pkg::*;
#(
  parameter int N     = CAPACITY_D,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic [CNT_W-1:0] idx_in [N],
  input  cell_flag_t       flag_in [N],
  output logic [CNT_W-1:0] idx_out,
  output cell_flag_t       flag_out
);

  localparam int NGRP = (N + GROUP - 1) / GROUP;

  logic [CNT_W-1:0] grp_idx [NGRP];
  cell_flag_t       grp_flag [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [CNT_W-1:0] idx_or;
    cell_flag_t       flag_or;

    always_comb begin
      idx_or  = '0;
      flag_or = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < N) begin
          idx_or  = idx_or | idx_in[g * GROUP + k];
          flag_or = flag_or | flag_in[g * GROUP + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      grp_idx[g]  <= idx_or;
      grp_flag[g] <= flag_or;
    end
  end

  always_comb begin
    idx_out  = '0;
    flag_out = '0;
    for (int g = 0; g < NGRP; g++) begin
      idx_out  = idx_out | grp_idx[g];
      flag_out = flag_out | grp_flag[g];
    end
  end

endmodule

@@ design/sorted_key_table.sv @@
// channel | direction | payload | handshake
// req     | in        | req_t   | req_valid / req_ready
// rsp     | out       | rsp_t   | rsp_valid / rsp_ready
//
// each transaction runs through accept, compare in every cell, group
// reduction, final combine with result write and table shift on insert.
// one transaction is in flight at a time; the next is taken while a result waits.
// a stalled rsp holds the block in its last step until the result slot frees.
// rst is synchronous; it empties the table (count to zero), no clearing pass.
// depends on skt_pkg, skt_cell, skt_reduce and sorted_key_table_defines.svh
`include "sorted_key_table_defines.svh"

module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_D,
  parameter int CODE_BITS = CODE_BITS_D
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t state, state_next;
  logic   fin_go;
  logic   commit;

  req_t             req_q;
  logic [CNT_W-1:0] count;

  logic [CODE_BITS-1:0] key;
  logic [PW-1:0]        pos_ext;

  logic [CODE_BITS-1:0] code_vec [CAPACITY];
  logic                 lt_vec [CAPACITY];
  logic [CNT_W-1:0]     idx_vec [CAPACITY];
  cell_flag_t           flag_vec [CAPACITY];

  logic [CNT_W-1:0] idx_any;
  cell_flag_t       flag_any;
  status_t          ins_status;
  rsp_t             rsp_next;

  assign key     = CODE_BITS'(req_q.code);
  assign pos_ext = PW'(req_q.position);

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = S_CMP;
      S_CMP:  state_next = S_RED;
      S_RED:  state_next = S_FIN;
      S_FIN:  if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    fin_go    = 1'b0;
    case (state)
      S_IDLE:  req_ready = 1'b1;
      S_FIN:   fin_go = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CODE_BITS-1:0] prev;
    logic                 nlt;

    if (i == 0) begin : g_first
      assign prev = key;
    end else begin : g_rest
      assign prev = code_vec[i - 1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nlt = 1'b0;
    end else begin : g_mid
      assign nlt = lt_vec[i + 1];
    end

    skt_cell #(
      .IDX    (i),
      .CODE_B (CODE_BITS),
      .CNT_W  (CNT_W),
      .PW     (PW)
    ) u_cell (
      .clk       (clk),
      .key       (key),
      .pos       (pos_ext),
      .count     (count),
      .shift_en  (commit),
      .prev_code (prev),
      .code      (code_vec[i]),
      .next_lt   (nlt),
      .lt        (lt_vec[i]),
      .idx       (idx_vec[i]),
      .flags     (flag_vec[i])
    );
  end

  skt_reduce #(
    .N     (CAPACITY),
    .CNT_W (CNT_W)
  ) u_reduce (
    .clk      (clk),
    .idx_in   (idx_vec),
    .flag_in  (flag_vec),
    .idx_out  (idx_any),
    .flag_out (flag_any)
  );

  // order checks win over the full check
  always_comb begin
    if (pos_ext > PW'(count) || flag_any.viol) begin
      ins_status = ST_BAD;
    end else if (count == CNT_W'(CAPACITY)) begin
      ins_status = ST_FULL;
    end else begin
      ins_status = ST_OK;
    end
  end

  assign commit = fin_go && req_q.cmd == CMD_INSERT && ins_status == ST_OK;

  always_comb begin
    if (req_q.cmd == CMD_INSERT) begin
      rsp_next.found  = 1'b0;
      rsp_next.index  = req_q.position;
      rsp_next.status = ins_status;
    end else begin
      rsp_next.found  = flag_any.eq;
      rsp_next.index  = POS_W'(idx_any);
      rsp_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (commit) begin
        count <= count + CNT_W'(1);
      end
      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp <= rsp_next;
    end
  end

  `SKT_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `SKT_ASSERT_NEXT(a_count_inc, clk, rst, commit, count == $past(count) + CNT_W'(1))
  `SKT_ASSERT_IMPL(a_full_only, clk, rst, fin_go && rsp_next.status == ST_FULL, count == CNT_W'(CAPACITY))
  `SKT_ASSERT_IMPL(a_result_slot, clk, rst, fin_go, !rsp_valid || rsp_ready)

endmodule
